### hw/rtl/bpr_pkg.sv
// ----------------------------------------------------------------------------
// Block part reassembly package
// Shared constants, codes and interface types of the reassembly unit.
// ----------------------------------------------------------------------------
package bpr_pkg;

    localparam int PART_BYTES       = 64;
    localparam int PART_AW          = $clog2(PART_BYTES);
    localparam int MAX_PARTS        = 64;
    localparam int MAP_IW           = $clog2(MAX_PARTS);
    localparam int CNT_W            = $clog2(MAX_PARTS + 1);
    localparam int BUFFER_BYTES     = 4096;
    localparam int BUF_AW           = $clog2(BUFFER_BYTES);
    localparam int FULL_BLOCK_BYTES = 4096;
    localparam int HDR_BYTES        = 4;
    localparam int SIZE_MAX         = BUFFER_BYTES - HDR_BYTES;
    localparam int BSIZE_W          = 13;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_PART  = 2'd1;
    localparam logic [1:0] OP_CHECK = 2'd2;

    localparam logic [1:0] REJ_NONE  = 2'd0;
    localparam logic [1:0] REJ_BLOCK = 2'd1;
    localparam logic [1:0] REJ_RANGE = 2'd2;
    localparam logic [1:0] REJ_SUM   = 2'd3;

    typedef struct packed {
        logic              copy_go;
        logic              check_go;
        logic [BUF_AW-1:0] copy_base;
    } store_cmd_t;

    typedef struct packed {
        logic busy;
        logic check_done;
        logic sum_ok;
    } store_stat_t;

endpackage

### hw/rtl/bpr_stage.sv
// ----------------------------------------------------------------------------
// Part staging buffer
// Holds the bytes of the part in flight and keeps its running 8-bit sum.
// ----------------------------------------------------------------------------
module bpr_stage
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [bpr_pkg::PART_AW-1:0] wr_addr,
    input  logic [7:0]                  wr_data,
    output logic [7:0]                  sum_next,
    input  logic                        rd_en,
    input  logic [bpr_pkg::PART_AW-1:0] rd_addr,
    output logic [7:0]                  rd_data
);

    logic [7:0] mem [bpr_pkg::PART_BYTES];
    logic [7:0] sum_reg;
    logic [7:0] rd_data_reg;

    assign sum_next = ((wr_addr == '0) ? 8'd0 : sum_reg) + wr_data;
    assign rd_data  = rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (wr_en)
        begin
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

### hw/rtl/bpr_store.sv
// ----------------------------------------------------------------------------
// Block store
// Block buffer memory with the part copy sequencer and the header/sum walker.
// ----------------------------------------------------------------------------
module bpr_store
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  bpr_pkg::store_cmd_t         cmd,
    output bpr_pkg::store_stat_t        stat,
    output logic                        stage_rd_en,
    output logic [bpr_pkg::PART_AW-1:0] stage_rd_addr,
    input  logic [7:0]                  stage_rd_data
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_COPY  = 2'd1;
    localparam logic [1:0] ST_CHECK = 2'd2;

    logic [7:0] mem [bpr_pkg::BUFFER_BYTES];

    logic [1:0]                  state_reg, state_next;
    logic [bpr_pkg::BUF_AW:0]    cnt_reg, cnt_next;
    logic [bpr_pkg::BUF_AW-1:0]  base_reg;
    logic                        rd_vld_reg;
    logic [bpr_pkg::BUF_AW-1:0]  rd_tag_reg, rd_tag_next;
    logic [7:0]                  mem_q_reg;
    logic [7:0]                  lo_reg;
    logic [bpr_pkg::BUF_AW-1:0]  size_reg;
    logic [15:0]                 want_reg;
    logic [15:0]                 sum_reg;
    logic                        copy_issue;
    logic                        chk_issue;
    logic                        chk_data;
    logic [15:0]                 hdr_size;
    logic [bpr_pkg::BUF_AW-1:0]  wr_addr;

    assign copy_issue = (state_reg == ST_COPY)
                        && (cnt_reg < (bpr_pkg::BUF_AW+1)'(bpr_pkg::PART_BYTES));
    assign chk_issue  = (state_reg == ST_CHECK)
                        && ((cnt_reg < (bpr_pkg::BUF_AW+1)'(bpr_pkg::HDR_BYTES))
                        || ((cnt_reg - (bpr_pkg::BUF_AW+1)'(bpr_pkg::HDR_BYTES))
                            < {1'b0, size_reg}));
    assign chk_data   = (state_reg == ST_CHECK) && rd_vld_reg;
    assign hdr_size   = {mem_q_reg, lo_reg};
    assign wr_addr    = base_reg + rd_tag_reg;

    assign stage_rd_en   = copy_issue;
    assign stage_rd_addr = cnt_reg[bpr_pkg::PART_AW-1:0];

    assign stat.busy       = (state_reg != ST_IDLE);
    assign stat.check_done = (state_reg == ST_CHECK) && !chk_issue && !rd_vld_reg;
    assign stat.sum_ok     = (sum_reg == want_reg);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        rd_tag_next = cnt_reg[bpr_pkg::BUF_AW-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (cmd.copy_go)
                begin
                    state_next = ST_COPY;
                end
                else if (cmd.check_go)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_COPY:
            begin
                if (copy_issue)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                else if (!rd_vld_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CHECK:
            begin
                if (chk_issue)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                else if (!rd_vld_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            rd_vld_reg <= copy_issue || chk_issue;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_tag_reg <= rd_tag_next;
        if ((state_reg == ST_IDLE) && cmd.copy_go)
        begin
            base_reg <= cmd.copy_base;
        end
        if ((state_reg == ST_IDLE) && cmd.check_go)
        begin
            sum_reg <= '0;
        end
        else if (chk_data && (rd_tag_reg >= bpr_pkg::BUF_AW'(bpr_pkg::HDR_BYTES)))
        begin
            sum_reg <= sum_reg + {8'd0, mem_q_reg};
        end
        if (chk_data)
        begin
            unique case (rd_tag_reg)
                bpr_pkg::BUF_AW'(0):
                begin
                    lo_reg <= mem_q_reg;
                end
                bpr_pkg::BUF_AW'(1):
                begin
                    size_reg <= (hdr_size > 16'(bpr_pkg::SIZE_MAX))
                                ? bpr_pkg::BUF_AW'(bpr_pkg::SIZE_MAX)
                                : hdr_size[bpr_pkg::BUF_AW-1:0];
                end
                bpr_pkg::BUF_AW'(2):
                begin
                    want_reg[7:0] <= mem_q_reg;
                end
                bpr_pkg::BUF_AW'(3):
                begin
                    want_reg[15:8] <= mem_q_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_COPY) && rd_vld_reg)
        begin
            mem[wr_addr] <= stage_rd_data;
        end
        if (chk_issue)
        begin
            mem_q_reg <= mem[cnt_reg[bpr_pkg::BUF_AW-1:0]];
        end
    end

endmodule

### hw/rtl/block_part_reassembly_unit.sv
// Start, part-byte and status-only transactions give their result in the cycle after
// acceptance. An accepted last byte of a part that passes its checks triggers a 64-byte
// copy from the staging buffer into the block store, during which input is held off.
// A check on a complete block walks the stored header and data, one byte per cycle over
// the block store read port. Reset is asynchronous and clears all control state;
// the memories are not cleared.
// ----------------------------------------------------------------------------
// Block part reassembly unit
// Stages incoming parts, verifies them, commits them to the block store and
// tracks the missing-parts bitmap and block validity.
// ----------------------------------------------------------------------------
module block_part_reassembly_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // block_id[7:0], block_size[20:8], part_index[28:21], byte_index[34:29],
    // data_byte[42:35], part_checksum[50:43], zero fill above.
    input  logic [55:0] s_tdata,
    // opcode[1:0].
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // part_done[0], reject_code[2:1], block_complete[3], block_valid[4],
    // parts_missing[11:5], request_partial[12], zero fill above.
    output logic [15:0] m_tdata
);

    localparam int IDX_W = 8;
    localparam int START_W = IDX_W + bpr_pkg::PART_AW;

    logic [1:0]                  opcode;
    logic [7:0]                  block_id;
    logic [bpr_pkg::BSIZE_W-1:0] block_size;
    logic [IDX_W-1:0]            part_index;
    logic [bpr_pkg::PART_AW-1:0] byte_index;
    logic [7:0]                  data_byte;
    logic [7:0]                  part_checksum;

    logic [7:0]                    target_reg, target_next;
    logic [bpr_pkg::CNT_W-1:0]     expected_reg, expected_next;
    logic [bpr_pkg::MAX_PARTS-1:0] map_reg, map_next;
    logic [bpr_pkg::CNT_W-1:0]     count_reg, count_next;
    logic                          partial_reg, partial_next;
    logic                          chk_wait_reg, chk_wait_next;
    logic                          out_valid_reg;
    logic [15:0]                   out_data_reg;

    logic                          accept;
    logic                          load_res;
    logic                          res_done;
    logic [1:0]                    res_reject;
    logic                          res_valid;
    logic [bpr_pkg::MAX_PARTS-1:0] exp_mask;
    logic [bpr_pkg::BSIZE_W-1:0]   bsize_sat;
    logic [bpr_pkg::BSIZE_W:0]     parts_raw;
    logic [bpr_pkg::CNT_W-1:0]     parts_new;
    logic [START_W-1:0]            start_addr;
    logic                          is_last;
    logic                          range_bad;
    logic [7:0]                    stage_sum;
    logic [7:0]                    csum;
    logic                          stage_wr;
    logic                          stage_rd_en;
    logic [bpr_pkg::PART_AW-1:0]   stage_rd_addr;
    logic [7:0]                    stage_rd_data;
    bpr_pkg::store_cmd_t           st_cmd;
    bpr_pkg::store_stat_t          st_stat;

    assign opcode        = s_tuser;
    assign block_id      = s_tdata[7:0];
    assign block_size    = s_tdata[20:8];
    assign part_index    = s_tdata[28:21];
    assign byte_index    = s_tdata[34:29];
    assign data_byte     = s_tdata[42:35];
    assign part_checksum = s_tdata[50:43];

    assign s_tready = !st_stat.busy && !chk_wait_reg && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign exp_mask = (expected_reg >= bpr_pkg::CNT_W'(bpr_pkg::MAX_PARTS))
                      ? '1
                      : ((bpr_pkg::MAX_PARTS)'(1) << expected_reg) - 1'b1;

    assign bsize_sat = (block_size > bpr_pkg::BSIZE_W'(bpr_pkg::BUFFER_BYTES))
                       ? bpr_pkg::BSIZE_W'(bpr_pkg::BUFFER_BYTES) : block_size;
    assign parts_raw = ({1'b0, bsize_sat} + (bpr_pkg::BSIZE_W+1)'(bpr_pkg::PART_BYTES - 1))
                       >> bpr_pkg::PART_AW;
    assign parts_new = ((block_size == bpr_pkg::BSIZE_W'(bpr_pkg::FULL_BLOCK_BYTES))
                        || (parts_raw > (bpr_pkg::BSIZE_W+1)'(bpr_pkg::MAX_PARTS)))
                       ? bpr_pkg::CNT_W'(bpr_pkg::MAX_PARTS)
                       : parts_raw[bpr_pkg::CNT_W-1:0];

    assign start_addr = {part_index, {bpr_pkg::PART_AW{1'b0}}};
    assign is_last    = (byte_index == bpr_pkg::PART_AW'(bpr_pkg::PART_BYTES - 1));
    assign range_bad  = (start_addr >= START_W'(bpr_pkg::BUFFER_BYTES - 1))
                        || (part_index >= IDX_W'(bpr_pkg::MAX_PARTS));
    assign csum       = block_id + part_index + stage_sum;
    assign stage_wr   = accept && (opcode == bpr_pkg::OP_PART);

    always_comb
    begin
        target_next      = target_reg;
        expected_next    = expected_reg;
        map_next         = map_reg;
        count_next       = count_reg;
        partial_next     = partial_reg;
        chk_wait_next    = chk_wait_reg;
        load_res         = 1'b0;
        res_done         = 1'b0;
        res_reject       = bpr_pkg::REJ_NONE;
        res_valid        = 1'b0;
        st_cmd.copy_go   = 1'b0;
        st_cmd.check_go  = 1'b0;
        st_cmd.copy_base = start_addr[bpr_pkg::BUF_AW-1:0];
        priority if (st_stat.check_done && chk_wait_reg)
        begin
            chk_wait_next = 1'b0;
            load_res      = 1'b1;
            if (st_stat.sum_ok)
            begin
                res_valid = 1'b1;
            end
            else
            begin
                map_next     = exp_mask;
                count_next   = expected_reg;
                partial_next = 1'b0;
            end
        end
        else if (accept)
        begin
            load_res = 1'b1;
            unique case (opcode)
                bpr_pkg::OP_START:
                begin
                    target_next   = block_id;
                    expected_next = parts_new;
                    map_next      = (parts_new >= bpr_pkg::CNT_W'(bpr_pkg::MAX_PARTS))
                                    ? '1
                                    : ((bpr_pkg::MAX_PARTS)'(1) << parts_new) - 1'b1;
                    count_next    = parts_new;
                    partial_next  = 1'b0;
                end
                bpr_pkg::OP_PART:
                begin
                    if (is_last)
                    begin
                        res_done = 1'b1;
                        priority if (block_id != target_reg)
                        begin
                            res_reject = bpr_pkg::REJ_BLOCK;
                        end
                        else if (range_bad)
                        begin
                            res_reject = bpr_pkg::REJ_RANGE;
                        end
                        else if (csum != part_checksum)
                        begin
                            res_reject = bpr_pkg::REJ_SUM;
                        end
                        else
                        begin
                            st_cmd.copy_go = 1'b1;
                            map_next[part_index[bpr_pkg::MAP_IW-1:0]] = 1'b0;
                            if (map_reg[part_index[bpr_pkg::MAP_IW-1:0]])
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                    end
                end
                bpr_pkg::OP_CHECK:
                begin
                    if (count_reg == '0)
                    begin
                        st_cmd.check_go = 1'b1;
                        chk_wait_next   = 1'b1;
                        load_res        = 1'b0;
                    end
                    else
                    begin
                        partial_next = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= '0;
            expected_reg  <= '0;
            map_reg       <= '0;
            count_reg     <= '0;
            partial_reg   <= 1'b0;
            chk_wait_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            target_reg   <= target_next;
            expected_reg <= expected_next;
            map_reg      <= map_next;
            count_reg    <= count_next;
            partial_reg  <= partial_next;
            chk_wait_reg <= chk_wait_next;
            if (load_res)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_res)
        begin
            out_data_reg <= {3'd0, partial_next, count_next, res_valid,
                             (count_next == '0), res_reject, res_done};
        end
    end

    bpr_stage u_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (stage_wr),
        .wr_addr  (byte_index),
        .wr_data  (data_byte),
        .sum_next (stage_sum),
        .rd_en    (stage_rd_en),
        .rd_addr  (stage_rd_addr),
        .rd_data  (stage_rd_data)
    );

    bpr_store u_store
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (st_cmd),
        .stat          (st_stat),
        .stage_rd_en   (stage_rd_en),
        .stage_rd_addr (stage_rd_addr),
        .stage_rd_data (stage_rd_data)
    );

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        st_stat.busy |-> !s_tready)
        else $error("Input accepted while the block store is busy.");

    a_count_matches_map: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(map_reg) == 32'(count_reg))
        else $error("Missing count disagrees with the missing-parts bitmap.");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= expected_reg)
        else $error("Missing count exceeds the expected part count.");

    a_check_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        st_stat.check_done |-> chk_wait_reg)
        else $error("Block check finished without a pending check transaction.");

endmodule

### tb/block_part_reassembly_unit_test.sv
// ----------------------------------------------------------------------------
// Block part reassembly unit testbench
// Streams start, part-byte, check and unknown-opcode transactions into the
// unit under several sender idle and receiver stall patterns. A scoreboard
// keeps its own copy of the block state and checks every status result.
// ----------------------------------------------------------------------------
module block_part_reassembly_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 100;
    localparam int PHASE_ITEMS = 280;

    typedef struct {
        logic [1:0]                  opcode;
        logic [7:0]                  block_id;
        logic [bpr_pkg::BSIZE_W-1:0] block_size;
        logic [7:0]                  part_index;
        logic [bpr_pkg::PART_AW-1:0] byte_index;
        logic [7:0]                  data_byte;
        logic [7:0]                  part_checksum;
    } xfer_t;

    typedef struct {
        logic                      part_done;
        logic [1:0]                reject_code;
        logic                      block_complete;
        logic                      block_valid;
        logic [bpr_pkg::CNT_W-1:0] parts_missing;
        logic                      request_partial;
    } status_t;

    typedef enum int {PM_GOOD, PM_BAD_SUM, PM_WRONG_ID, PM_TRUNC, PM_RANGE} part_mode_t;

    class reassembly_scoreboard;
        logic [7:0]  target_id;
        int unsigned parts_exp;
        logic [63:0] missing;
        logic [7:0]  stage [bpr_pkg::PART_BYTES];
        bit          stage_wr [bpr_pkg::PART_BYTES];
        logic [7:0]  run_sum;
        logic [7:0]  store [bpr_pkg::BUFFER_BYTES];
        bit          store_wr [bpr_pkg::BUFFER_BYTES];
        logic        partial;
        status_t     pending_q [$];
        int          errors;
        int          results;
        int          valid_blocks;
        int          rejects [4];

        function new();
            target_id = '0;
            parts_exp = 0;
            missing = '0;
            run_sum = '0;
            partial = 1'b0;
            errors = 0;
            results = 0;
            valid_blocks = 0;
            foreach (rejects[i]) rejects[i] = 0;
        endfunction

        function logic [63:0] expect_mask();
            if (parts_exp >= 64)
                return '1;
            return (64'd1 << parts_exp) - 64'd1;
        endfunction

        function int unsigned missing_count();
            return $countones(missing & expect_mask());
        endfunction

        function logic [7:0] next_sum(xfer_t x);
            return (x.byte_index == 0) ? x.data_byte : 8'(run_sum + x.data_byte);
        endfunction

        function logic [1:0] part_verdict(xfer_t x, logic [7:0] sum_now);
            int unsigned base;
            base = x.part_index * bpr_pkg::PART_BYTES;
            if (x.block_id != target_id)
                return bpr_pkg::REJ_BLOCK;
            if (base >= bpr_pkg::BUFFER_BYTES - 1 || x.part_index >= bpr_pkg::MAX_PARTS)
                return bpr_pkg::REJ_RANGE;
            if (8'(x.block_id + x.part_index + sum_now) != x.part_checksum)
                return bpr_pkg::REJ_SUM;
            return bpr_pkg::REJ_NONE;
        endfunction

        function bit header_span_written();
            int unsigned len;
            for (int i = 0; i < bpr_pkg::HDR_BYTES; i++)
                if (!store_wr[i])
                    return 1'b0;
            len = {store[1], store[0]};
            if (len > bpr_pkg::SIZE_MAX)
                len = bpr_pkg::SIZE_MAX;
            for (int unsigned i = 0; i < len; i++)
                if (!store_wr[bpr_pkg::HDR_BYTES + i])
                    return 1'b0;
            return 1'b1;
        endfunction

        function bit data_sum_matches();
            int unsigned len;
            logic [15:0] acc;
            logic [15:0] want;
            len = {store[1], store[0]};
            want = {store[3], store[2]};
            if (len > bpr_pkg::SIZE_MAX)
                len = bpr_pkg::SIZE_MAX;
            acc = '0;
            for (int unsigned i = 0; i < len; i++)
                acc = acc + 16'(store[bpr_pkg::HDR_BYTES + i]);
            return acc == want;
        endfunction

        // Storage that was never written must not be read by the unit, so a
        // commit from a partly written stage gets a wrong checksum and a check
        // that would walk unwritten bytes becomes a status-only transaction.
        function xfer_t made_safe(xfer_t x);
            bit stage_full;
            stage_full = 1'b1;
            for (int i = 0; i < bpr_pkg::PART_BYTES - 1; i++)
                if (!stage_wr[i])
                    stage_full = 1'b0;
            if (x.opcode == bpr_pkg::OP_PART && x.byte_index == bpr_pkg::PART_BYTES - 1 &&
                !stage_full && part_verdict(x, next_sum(x)) == bpr_pkg::REJ_NONE)
                x.part_checksum = x.part_checksum + 8'd1;
            if (x.opcode == bpr_pkg::OP_CHECK && missing_count() == 0 &&
                !header_span_written())
                x.opcode = OP_NONE;
            return x;
        endfunction

        function void note_input(xfer_t x);
            status_t s;
            logic [7:0] sum_now;
            int unsigned sz;
            int unsigned base;
            s = '{default: '0};
            case (x.opcode)
                bpr_pkg::OP_START:
                begin
                    target_id = x.block_id;
                    if (x.block_size == bpr_pkg::FULL_BLOCK_BYTES)
                    begin
                        parts_exp = bpr_pkg::MAX_PARTS;
                    end
                    else
                    begin
                        sz = (x.block_size > bpr_pkg::BUFFER_BYTES) ? bpr_pkg::BUFFER_BYTES
                                                                     : x.block_size;
                        parts_exp = (sz + bpr_pkg::PART_BYTES - 1) / bpr_pkg::PART_BYTES;
                        if (parts_exp > bpr_pkg::MAX_PARTS)
                            parts_exp = bpr_pkg::MAX_PARTS;
                    end
                    missing = expect_mask();
                    partial = 1'b0;
                end
                bpr_pkg::OP_PART:
                begin
                    sum_now = next_sum(x);
                    stage[x.byte_index] = x.data_byte;
                    stage_wr[x.byte_index] = 1'b1;
                    run_sum = sum_now;
                    if (x.byte_index == bpr_pkg::PART_BYTES - 1)
                    begin
                        s.part_done = 1'b1;
                        s.reject_code = part_verdict(x, sum_now);
                        if (s.reject_code == bpr_pkg::REJ_NONE)
                        begin
                            base = x.part_index * bpr_pkg::PART_BYTES;
                            sz = bpr_pkg::PART_BYTES;
                            if (base + sz > bpr_pkg::BUFFER_BYTES)
                                sz = bpr_pkg::BUFFER_BYTES - base;
                            for (int unsigned i = 0; i < sz; i++)
                            begin
                                store[base + i] = stage[i];
                                store_wr[base + i] = 1'b1;
                            end
                            missing[x.part_index[bpr_pkg::MAP_IW-1:0]] = 1'b0;
                        end
                        rejects[s.reject_code]++;
                    end
                end
                bpr_pkg::OP_CHECK:
                begin
                    if (missing_count() == 0)
                    begin
                        if (data_sum_matches())
                        begin
                            s.block_valid = 1'b1;
                            valid_blocks++;
                        end
                        else
                        begin
                            missing = missing | expect_mask();
                            partial = 1'b0;
                        end
                    end
                    else
                    begin
                        partial = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            s.block_complete = (missing_count() == 0);
            s.parts_missing = bpr_pkg::CNT_W'(missing_count());
            s.request_partial = partial;
            pending_q.push_back(s);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40)
                $display("MISMATCH: %s", msg);
        endtask

        task check_result(logic [15:0] word);
            status_t want;
            string diff;
            results++;
            if (pending_q.size() == 0)
            begin
                report($sformatf("result %0d (%h) arrived with nothing expected", results, word));
                return;
            end
            want = pending_q.pop_front();
            diff = "";
            if (word[0] !== want.part_done)
                diff = {diff, $sformatf(" part_done %b/%b", word[0], want.part_done)};
            if (word[2:1] !== want.reject_code)
                diff = {diff, $sformatf(" reject_code %0d/%0d", word[2:1], want.reject_code)};
            if (word[3] !== want.block_complete)
                diff = {diff, $sformatf(" block_complete %b/%b", word[3], want.block_complete)};
            if (word[4] !== want.block_valid)
                diff = {diff, $sformatf(" block_valid %b/%b", word[4], want.block_valid)};
            if (word[11:5] !== want.parts_missing)
                diff = {diff, $sformatf(" parts_missing %0d/%0d", word[11:5], want.parts_missing)};
            if (word[12] !== want.request_partial)
                diff = {diff, $sformatf(" request_partial %b/%b", word[12], want.request_partial)};
            if (diff != "")
                report($sformatf("result %0d got/expected:%s", results, diff));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    reassembly_scoreboard sb;
    int idle_pct = 0;
    int stall_pct = 0;
    int sent = 0;
    int idle_cycles;
    logic [7:0] blk [bpr_pkg::BUFFER_BYTES];

    block_part_reassembly_unit i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
        end
        $display("Watchdog: no transaction for %0d cycles.", WATCHDOG_LIMIT);
        $display("block_part_reassembly_unit test failed");
        $finish;
    end

    function automatic xfer_t mk(logic [1:0] op, logic [7:0] bid, logic [12:0] bsize,
                                 logic [7:0] pidx, logic [5:0] bidx, logic [7:0] d,
                                 logic [7:0] cs);
        xfer_t x;
        x.opcode = op;
        x.block_id = bid;
        x.block_size = bsize;
        x.part_index = pidx;
        x.byte_index = bidx;
        x.data_byte = d;
        x.part_checksum = cs;
        return x;
    endfunction

    task automatic send(input xfer_t raw);
        xfer_t x;
        x = sb.made_safe(raw);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= x.opcode;
        s_tdata <= {5'd0, x.part_checksum, x.data_byte, x.byte_index, x.part_index,
                    x.block_size, x.block_id};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input(x);
        sent++;
    endtask

    task automatic send_random(input logic [1:0] op);
        send(mk(op, 8'($urandom), 13'($urandom), 8'($urandom), 6'($urandom),
                8'($urandom), 8'($urandom)));
    endtask

    task automatic send_check();
        send_random(bpr_pkg::OP_CHECK);
    endtask

    task automatic send_part(input logic [7:0] bid, input int pidx, input part_mode_t mode);
        logic [7:0] id;
        logic [7:0] idx;
        logic [7:0] cs;
        logic [7:0] d;
        int last;
        id = (mode == PM_WRONG_ID) ? bid ^ 8'($urandom_range(1, 255)) : bid;
        idx = (mode == PM_RANGE) ? 8'($urandom_range(bpr_pkg::MAX_PARTS, 255)) : 8'(pidx);
        last = (mode == PM_TRUNC) ? int'($urandom_range(0, bpr_pkg::PART_BYTES - 2))
                                  : bpr_pkg::PART_BYTES - 1;
        cs = id + idx;
        for (int i = 0; i <= last; i++)
        begin
            d = blk[pidx * bpr_pkg::PART_BYTES + i];
            cs = cs + d;
            if (i == bpr_pkg::PART_BYTES - 1)
                send(mk(bpr_pkg::OP_PART, id, 13'($urandom), idx, 6'(i), d,
                        (mode == PM_BAD_SUM) ? 8'(cs + 8'd1) : cs));
            else
                send(mk(bpr_pkg::OP_PART, id, 13'($urandom), idx, 6'(i), d, 8'($urandom)));
        end
    endtask

    // One block: start, parts in random order with occasional broken copies,
    // then a check. A block sent with a wrong header sum fails validation and
    // is sent once more with the header corrected.
    task automatic run_block(input logic [12:0] size_req);
        logic [7:0] bid;
        int n;
        int cap;
        int unsigned hsz;
        logic [15:0] sum;
        logic [15:0] want;
        bit bad_hdr;
        int order [$];
        int j;
        int tmp;
        bid = 8'($urandom);
        send(mk(bpr_pkg::OP_START, bid, size_req, 8'($urandom), 6'($urandom),
                8'($urandom), 8'($urandom)));
        n = int'(sb.parts_exp);
        cap = n * bpr_pkg::PART_BYTES;
        if (n == 0)
        begin
            send_check();
            return;
        end
        for (int i = 0; i < cap; i++)
            blk[i] = 8'($urandom);
        hsz = $urandom_range(0, cap - bpr_pkg::HDR_BYTES);
        sum = '0;
        for (int unsigned i = 0; i < hsz; i++)
            sum = sum + 16'(blk[bpr_pkg::HDR_BYTES + i]);
        bad_hdr = ($urandom_range(4) == 0);
        want = bad_hdr ? sum ^ 16'($urandom_range(1, 16'hFFFF)) : sum;
        blk[0] = hsz[7:0];
        blk[1] = hsz[15:8];
        blk[2] = want[7:0];
        blk[3] = want[15:8];
        for (int pass = 0; pass <= int'(bad_hdr); pass++)
        begin
            order.delete();
            for (int i = 0; i < n; i++)
                order.push_back(i);
            for (int i = n - 1; i > 0; i--)
            begin
                j = int'($urandom_range(i));
                tmp = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
            foreach (order[k])
            begin
                if ($urandom_range(9) == 0)
                    send_part(bid, order[k],
                              part_mode_t'($urandom_range(int'(PM_BAD_SUM), int'(PM_RANGE))));
                send_part(bid, order[k], PM_GOOD);
                if ($urandom_range(19) == 0)
                    send_check();
            end
            send_check();
            blk[2] = sum[7:0];
            blk[3] = sum[15:8];
        end
    endtask

    initial
    begin
        int phase_idle [4];
        int phase_stall [4];
        int goal;
        int pick;
        phase_idle = '{0, 66, 0, 36};
        phase_stall = '{0, 0, 66, 36};
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(mk(OP_NONE, 8'hFF, 13'h1FFF, 8'hFF, 6'h3F, 8'hFF, 8'hFF));
        send(mk(bpr_pkg::OP_START, 8'h00, 13'd0, 8'h00, 6'h00, 8'h00, 8'h00));
        send(mk(bpr_pkg::OP_START, 8'hFF, 13'(bpr_pkg::FULL_BLOCK_BYTES), 8'hFF, 6'h3F,
                8'hFF, 8'hFF));
        send(mk(bpr_pkg::OP_START, 8'h3C, 13'h1FFF, 8'h00, 6'h00, 8'h00, 8'h00));
        send(mk(bpr_pkg::OP_START, 8'h3C, 13'(bpr_pkg::BUFFER_BYTES - 1), 8'h00, 6'h00,
                8'h00, 8'h00));
        send(mk(bpr_pkg::OP_START, 8'hA5, 13'(bpr_pkg::PART_BYTES + 1), 8'h00, 6'h00,
                8'h00, 8'h00));
        send_check();
        send(mk(bpr_pkg::OP_PART, 8'hA5, 13'd0, 8'h00, 6'd0, 8'hFF, 8'h00));
        send(mk(bpr_pkg::OP_PART, 8'hA5, 13'd0, 8'h00, 6'd1, 8'h00, 8'hFF));
        send(mk(bpr_pkg::OP_PART, 8'h5A, 13'd0, 8'h00, 6'(bpr_pkg::PART_BYTES - 1),
                8'h12, 8'h34));
        send(mk(bpr_pkg::OP_PART, 8'hA5, 13'd0, 8'hFF, 6'(bpr_pkg::PART_BYTES - 1),
                8'h56, 8'h78));
        send(mk(bpr_pkg::OP_PART, 8'hA5, 13'd0, 8'(bpr_pkg::MAX_PARTS),
                6'(bpr_pkg::PART_BYTES - 1), 8'h9A, 8'hBC));
        send(mk(bpr_pkg::OP_PART, 8'hA5, 13'd0, 8'h01, 6'(bpr_pkg::PART_BYTES - 1),
                8'hDE, 8'h00));
        send(mk(bpr_pkg::OP_START, 8'hA5, 13'(bpr_pkg::PART_BYTES), 8'h00, 6'h00,
                8'h00, 8'h00));
        send(mk(OP_NONE, 8'h00, 13'd0, 8'h00, 6'h00, 8'h00, 8'h00));

        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = phase_idle[ph];
            stall_pct = phase_stall[ph];
            goal = sent + PHASE_ITEMS;
            while (sent < goal)
            begin
                pick = int'($urandom_range(99));
                if (pick < 15)
                    repeat ($urandom_range(1, 6))
                        send_random(2'($urandom_range(3)));
                else if (pick < 20)
                    run_block(13'd0);
                else if (pick < 85)
                    run_block(13'($urandom_range(1, 2 * bpr_pkg::PART_BYTES)));
                else
                    run_block(13'($urandom_range(2 * bpr_pkg::PART_BYTES + 1,
                                                 5 * bpr_pkg::PART_BYTES)));
            end
        end
        s_tvalid <= 1'b0;

        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Summary: %0d input transactions, %0d results checked, %0d blocks validated.",
                 sent, sb.results, sb.valid_blocks);
        $display("Parts ended: %0d accepted, %0d wrong block, %0d out of range, %0d bad sum.",
                 sb.rejects[bpr_pkg::REJ_NONE], sb.rejects[bpr_pkg::REJ_BLOCK],
                 sb.rejects[bpr_pkg::REJ_RANGE], sb.rejects[bpr_pkg::REJ_SUM]);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("block_part_reassembly_unit test passed");
        else
            $display("block_part_reassembly_unit test failed");
        $finish;
    end

endmodule
